// ===== design/gcrp_pkg.sv =====
// Shared constants, types and print size tables for the corner-point rectangle packer.
package gcrp_pkg;

	localparam int PLACED_DEPTH = 64;
	localparam int BASE_DEPTH   = 128;
	localparam int ROLL_LENGTH  = 10000;

	localparam int PI_W = $clog2(PLACED_DEPTH);
	localparam int PC_W = $clog2(PLACED_DEPTH + 1);
	localparam int CI_W = $clog2(BASE_DEPTH);
	localparam int CC_W = $clog2(BASE_DEPTH + 1);
	localparam int CA_W = CI_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROLL_MODE   = 2'd2;

	typedef struct packed {
		logic [14:0] x;
		logic [14:0] y;
		logic [10:0] w;
		logic [10:0] h;
	} rect_t;

	typedef struct packed {
		logic [14:0] x;
		logic [14:0] y;
	} corner_t;

	typedef enum logic [16:0] {
		S_IDLE  = 17'b00000000000000001,
		S_NEWPG = 17'b00000000000000010,
		S_START = 17'b00000000000000100,
		S_CRD   = 17'b00000000000001000,
		S_CLAT  = 17'b00000000000010000,
		S_CAND  = 17'b00000000000100000,
		S_RECT  = 17'b00000000001000000,
		S_MUL   = 17'b00000000010000000,
		S_CMP   = 17'b00000000100000000,
		S_END   = 17'b00000001000000000,
		S_SHR   = 17'b00000010000000000,
		S_SHW   = 17'b00000100000000000,
		S_PUSH1 = 17'b00001000000000000,
		S_PUSH2 = 17'b00010000000000000,
		S_COMMIT = 17'b00100000000000000,
		S_EMIT  = 17'b01000000000000000,
		S_SPARE = 17'b10000000000000000
	} state_t;

	// sel 0 gives the short side, sel 1 the long side
	function automatic logic [10:0] print_dim(input logic [1:0] size, input logic sel);
		logic [10:0] d;
		case (size)
			2'd0: d = sel ? 11'd1440 : 11'd1152;
			2'd1: d = sel ? 11'd1008 : 11'd792;
			2'd2: d = sel ? 11'd720 : 11'd576;
			2'd3: d = sel ? 11'd504 : 11'd360;
			default: d = 11'd0;
		endcase
		return d;
	endfunction

	function automatic logic [20:0] print_area(input logic [1:0] size);
		logic [20:0] a;
		case (size)
			2'd0: a = 21'd1658880;
			2'd1: a = 21'd798336;
			2'd2: a = 21'd414720;
			2'd3: a = 21'd181440;
			default: a = 21'd0;
		endcase
		return a;
	endfunction

endpackage

// ===== design/gcrp_ifs.sv =====
// Request, result and configuration channel interfaces.
interface gcrp_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] count_16x20;
	logic [3:0] count_11x14;
	logic [3:0] count_8x10;
	logic [3:0] count_5x7;
	modport source (output valid, count_16x20, count_11x14, count_8x10, count_5x7,
		input ready);
	modport sink (input valid, count_16x20, count_11x14, count_8x10, count_5x7,
		output ready);
endinterface

interface gcrp_res_if;
	logic        valid;
	logic        ready;
	logic [5:0]  page_index;
	logic [14:0] pos_x;
	logic [14:0] pos_y;
	logic [10:0] rect_width;
	logic [10:0] rect_height;
	logic [1:0]  size_code;
	logic        rotated;
	logic        no_fit;
	logic        last;
	modport source (output valid, page_index, pos_x, pos_y, rect_width, rect_height,
		size_code, rotated, no_fit, last, input ready);
	modport sink (input valid, page_index, pos_x, pos_y, rect_width, rect_height,
		size_code, rotated, no_fit, last, output ready);
endinterface

interface gcrp_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [gcrp_pkg::CFG_IDX_W-1:0]   index;
	logic [gcrp_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/gcrp_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module gcrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/greedy_corner_rect_packer.sv =====
// Top level of the greedy corner-point rectangle packer.
// Channels: req takes one word of four print counts; res returns one word per
// placement (page, position, size, orientation), the last one flagged by last;
// cfg writes page width (0), page height (1) and roll_mode (2); write it only
// while idle, as the block does not enforce this. An empty request returns nothing.
// If a print fits no empty page, one word with no_fit=1 and last=1 ends the request.
// Each placement scans every stored corner (newest first), each remaining size in
// both orientations, and checks each candidate that clears the page edges against
// the placed rectangles of the page, one rectangle-memory read per cycle, stopping
// at the first overlap. The winning corner is then removed by shifting the later
// stored corners down over it; a page change adds a failed scan.
// Reset clears control state and restores the default media size; the stores need
// no clearing. A result waits in the output register while the receiver stalls;
// the packer works on the next placement and holds at its emit until the register
// is free. The next request is accepted as soon as the packer is idle, even with
// the final result still pending.
module greedy_corner_rect_packer (
	input  logic          clk,
	input  logic          arst_n,
	gcrp_req_if.sink      req,
	gcrp_res_if.source    res,
	gcrp_cfg_if.sink      cfg
);

	gcrp_pkg::state_t state_q;

	logic [13:0] mw_q;
	logic [14:0] mh_q;
	logic        roll_q;

	logic [3:0][3:0]            rem_q;
	logic [5:0]                 tot_q;
	logic [5:0]                 page_q;
	logic [gcrp_pkg::PC_W-1:0]  placed_cnt_q;
	logic [gcrp_pkg::CC_W-1:0]  corner_cnt_q;
	logic                       bank_q;
	logic [14:0]                hu_q;
	logic [27:0]                au_q;

	logic [gcrp_pkg::CC_W-1:0]  j_q;
	logic [gcrp_pkg::CC_W-1:0]  nn_q;
	logic [gcrp_pkg::CC_W-1:0]  k_q;
	logic [gcrp_pkg::PI_W-1:0]  rk_q;
	logic [3:0]                 cand_q;
	logic                       usable_q;
	logic [14:0]                cx_q;
	logic [14:0]                cy_q;

	logic                       have_best_q;
	logic [gcrp_pkg::CC_W-1:0]  best_idx_q;
	logic [16:0]                best_h_q;
	logic [28:0]                best_a_q;
	gcrp_pkg::rect_t            br_q;
	logic [1:0]                 best_sz_q;
	logic                       best_rot_q;
	logic                       err_q;

	logic [16:0] nh_q;
	logic [28:0] na_q;
	logic [45:0] pa_q;
	logic [45:0] pb_q;

	logic        res_valid_q;
	logic [5:0]  o_page_q;
	logic [14:0] o_x_q;
	logic [14:0] o_y_q;
	logic [10:0] o_w_q;
	logic [10:0] o_h_q;
	logic [1:0]  o_sz_q;
	logic        o_rot_q;
	logic        o_err_q;
	logic        o_last_q;

	// rectangle store
	logic                       pr_we;
	logic [gcrp_pkg::PI_W-1:0]  pr_waddr;
	logic [gcrp_pkg::PI_W-1:0]  pr_raddr;
	logic [51:0]                pr_rdata;
	gcrp_pkg::rect_t            prect;

	// corner store, two banks
	logic                       cr_we;
	logic [gcrp_pkg::CA_W-1:0]  cr_waddr;
	gcrp_pkg::corner_t          cr_wdata;
	logic [gcrp_pkg::CA_W-1:0]  cr_raddr;
	logic [29:0]                cr_rdata;
	gcrp_pkg::corner_t          crd;

	gcrp_ram #(.WIDTH(52), .DEPTH(gcrp_pkg::PLACED_DEPTH)) u_placed (
		.clk   (clk),
		.we    (pr_we),
		.waddr (pr_waddr),
		.wdata (br_q),
		.raddr (pr_raddr),
		.rdata (pr_rdata)
	);

	gcrp_ram #(.WIDTH(30), .DEPTH(2 * gcrp_pkg::BASE_DEPTH)) u_corner (
		.clk   (clk),
		.we    (cr_we),
		.waddr (cr_waddr),
		.wdata (cr_wdata),
		.raddr (cr_raddr),
		.rdata (cr_rdata)
	);

	assign prect = gcrp_pkg::rect_t'(pr_rdata);
	assign crd   = gcrp_pkg::corner_t'(cr_rdata);

	// candidate geometry
	logic [1:0]  sz;
	logic        rot;
	logic [10:0] cw;
	logic [10:0] ch;
	logic [16:0] x17;
	logic [16:0] y17;
	logic [16:0] xw;
	logic [16:0] yh;
	logic [16:0] w17;
	logic [16:0] h17;
	logic        guard_blk;
	logic        rect_hit;
	logic [16:0] nh_c;
	logic [28:0] na_c;
	logic        emit_ok;
	logic        emit_fire;
	logic        cand_done;

	assign sz  = cand_q[2:1];
	assign rot = cand_q[0];
	assign cw  = gcrp_pkg::print_dim(sz, rot);
	assign ch  = gcrp_pkg::print_dim(sz, !rot);
	assign x17 = {2'b00, cx_q};
	assign y17 = {2'b00, cy_q};
	assign xw  = x17 + {6'd0, cw};
	assign yh  = y17 + {6'd0, ch};
	assign w17 = {3'b000, mw_q};
	assign h17 = roll_q ? 17'(gcrp_pkg::ROLL_LENGTH) : {2'b00, mh_q};

	// right strip spans x in [W,W+1), y in [0,H+1); bottom strip x in [0,W), y in [H,H+1)
	assign guard_blk = ((x17 < w17 + 17'd1) && (w17 < xw) && (y17 < h17 + 17'd1)) ||
		((w17 != 17'd0) && (x17 < w17) && (y17 < h17 + 17'd1) && (h17 < yh));

	assign rect_hit = (prect.w != 11'd0) && (prect.h != 11'd0) &&
		(x17 < {2'b00, prect.x} + {6'd0, prect.w}) && ({2'b00, prect.x} < xw) &&
		(y17 < {2'b00, prect.y} + {6'd0, prect.h}) && ({2'b00, prect.y} < yh);

	assign nh_c = ({2'b00, hu_q} > yh) ? {2'b00, hu_q} : yh;
	assign na_c = {1'b0, au_q} + {8'd0, gcrp_pkg::print_area(sz)};

	assign emit_ok   = !res_valid_q || res.ready;
	assign emit_fire = (state_q == gcrp_pkg::S_EMIT) && emit_ok;
	assign cand_done = (cand_q == 4'd8);

	always_comb begin
		pr_we    = (state_q == gcrp_pkg::S_COMMIT);
		pr_waddr = placed_cnt_q[gcrp_pkg::PI_W-1:0];
		pr_raddr = (state_q == gcrp_pkg::S_RECT) ? rk_q + 1'b1 : '0;

		cr_we    = 1'b0;
		cr_waddr = {!bank_q, nn_q[gcrp_pkg::CI_W-1:0]};
		cr_wdata = '{x: cx_q, y: cy_q};
		case (state_q)
			gcrp_pkg::S_NEWPG: begin
				cr_we    = 1'b1;
				cr_waddr = {bank_q, {gcrp_pkg::CI_W{1'b0}}};
				cr_wdata = '{x: 15'd0, y: 15'd0};
			end
			gcrp_pkg::S_CAND: begin
				cr_we = cand_done && usable_q;
			end
			gcrp_pkg::S_SHW: begin
				cr_we    = 1'b1;
				cr_waddr = {!bank_q, k_q[gcrp_pkg::CI_W-1:0]};
				cr_wdata = crd;
			end
			gcrp_pkg::S_PUSH1: begin
				cr_we    = (nn_q < gcrp_pkg::CC_W'(gcrp_pkg::BASE_DEPTH));
				cr_wdata = '{x: br_q.x + {4'd0, br_q.w}, y: br_q.y};
			end
			gcrp_pkg::S_PUSH2: begin
				cr_we    = (nn_q < gcrp_pkg::CC_W'(gcrp_pkg::BASE_DEPTH));
				cr_wdata = '{x: br_q.x, y: br_q.y + {4'd0, br_q.h}};
			end
			default: begin
				cr_we = 1'b0;
			end
		endcase

		if (state_q == gcrp_pkg::S_SHR) begin
			cr_raddr = {!bank_q, k_q[gcrp_pkg::CI_W-1:0] + 1'b1};
		end else begin
			cr_raddr = {bank_q, j_q[gcrp_pkg::CI_W-1:0] - 1'b1};
		end
	end

	assign req.ready = (state_q == gcrp_pkg::S_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_q   <= 14'd612;
			mh_q   <= 15'd792;
			roll_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				gcrp_pkg::CFG_PAGE_WIDTH:  mw_q   <= cfg.data[13:0];
				gcrp_pkg::CFG_PAGE_HEIGHT: mh_q   <= cfg.data;
				gcrp_pkg::CFG_ROLL_MODE:   roll_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gcrp_pkg::S_IDLE;
			res_valid_q  <= 1'b0;
			rem_q        <= '0;
			tot_q        <= '0;
			page_q       <= '0;
			placed_cnt_q <= '0;
			corner_cnt_q <= '0;
			bank_q       <= 1'b0;
			hu_q         <= '0;
			au_q         <= '0;
			have_best_q  <= 1'b0;
			err_q        <= 1'b0;
			usable_q     <= 1'b0;
			cand_q       <= '0;
			j_q          <= '0;
			nn_q         <= '0;
			k_q          <= '0;
			rk_q         <= '0;
		end else begin
			if (emit_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				gcrp_pkg::S_IDLE: begin
					if (req.valid) begin
						rem_q  <= {req.count_5x7, req.count_8x10, req.count_11x14,
							req.count_16x20};
						tot_q  <= {2'b00, req.count_16x20} + {2'b00, req.count_11x14} +
							{2'b00, req.count_8x10} + {2'b00, req.count_5x7};
						page_q <= '0;
						err_q  <= 1'b0;
						if ((req.count_16x20 | req.count_11x14 | req.count_8x10 |
							req.count_5x7) != 4'd0) begin
							state_q <= gcrp_pkg::S_NEWPG;
						end
					end
				end
				gcrp_pkg::S_NEWPG: begin
					corner_cnt_q <= gcrp_pkg::CC_W'(1);
					placed_cnt_q <= '0;
					hu_q         <= '0;
					au_q         <= '0;
					state_q      <= gcrp_pkg::S_START;
				end
				gcrp_pkg::S_START: begin
					have_best_q <= 1'b0;
					nn_q        <= '0;
					j_q         <= corner_cnt_q;
					if (placed_cnt_q >= gcrp_pkg::PC_W'(gcrp_pkg::PLACED_DEPTH)) begin
						state_q <= gcrp_pkg::S_END;
					end else begin
						state_q <= gcrp_pkg::S_CRD;
					end
				end
				gcrp_pkg::S_CRD: begin
					if (j_q == '0) begin
						state_q <= gcrp_pkg::S_END;
					end else begin
						j_q     <= j_q - 1'b1;
						state_q <= gcrp_pkg::S_CLAT;
					end
				end
				gcrp_pkg::S_CLAT: begin
					cx_q     <= crd.x;
					cy_q     <= crd.y;
					cand_q   <= '0;
					usable_q <= 1'b0;
					state_q  <= gcrp_pkg::S_CAND;
				end
				gcrp_pkg::S_CAND: begin
					if (cand_done) begin
						// keep the corner in the rebuilt list if anything fit there
						if (usable_q) begin
							nn_q <= nn_q + 1'b1;
						end
						state_q <= gcrp_pkg::S_CRD;
					end else if (rem_q[sz] == 4'd0 || guard_blk) begin
						cand_q <= cand_q + 1'b1;
					end else if (placed_cnt_q == '0) begin
						nh_q    <= nh_c;
						na_q    <= na_c;
						state_q <= gcrp_pkg::S_MUL;
					end else begin
						rk_q    <= '0;
						state_q <= gcrp_pkg::S_RECT;
					end
				end
				gcrp_pkg::S_RECT: begin
					if (rect_hit) begin
						cand_q  <= cand_q + 1'b1;
						state_q <= gcrp_pkg::S_CAND;
					end else if ({1'b0, rk_q} + 1'b1 == placed_cnt_q) begin
						nh_q    <= nh_c;
						na_q    <= na_c;
						state_q <= gcrp_pkg::S_MUL;
					end else begin
						rk_q <= rk_q + 1'b1;
					end
				end
				gcrp_pkg::S_MUL: begin
					pa_q    <= na_q * best_h_q;
					pb_q    <= best_a_q * nh_q;
					state_q <= gcrp_pkg::S_CMP;
				end
				gcrp_pkg::S_CMP: begin
					if (!have_best_q || pa_q > pb_q) begin
						have_best_q <= 1'b1;
						best_idx_q  <= nn_q;
						best_h_q    <= nh_q;
						best_a_q    <= na_q;
						best_sz_q   <= sz;
						best_rot_q  <= rot;
						br_q        <= '{x: cx_q, y: cy_q, w: cw, h: ch};
					end
					usable_q <= 1'b1;
					cand_q   <= cand_q + 1'b1;
					state_q  <= gcrp_pkg::S_CAND;
				end
				gcrp_pkg::S_END: begin
					if (!have_best_q) begin
						if (placed_cnt_q == '0) begin
							err_q   <= 1'b1;
							state_q <= gcrp_pkg::S_EMIT;
						end else begin
							page_q  <= page_q + 1'b1;
							state_q <= gcrp_pkg::S_NEWPG;
						end
					end else begin
						// drop the winning corner by shifting the tail down
						nn_q    <= nn_q - 1'b1;
						k_q     <= best_idx_q;
						state_q <= gcrp_pkg::S_SHR;
					end
				end
				gcrp_pkg::S_SHR: begin
					if (k_q < nn_q) begin
						state_q <= gcrp_pkg::S_SHW;
					end else begin
						state_q <= gcrp_pkg::S_PUSH1;
					end
				end
				gcrp_pkg::S_SHW: begin
					k_q     <= k_q + 1'b1;
					state_q <= gcrp_pkg::S_SHR;
				end
				gcrp_pkg::S_PUSH1: begin
					if (nn_q < gcrp_pkg::CC_W'(gcrp_pkg::BASE_DEPTH)) begin
						nn_q <= nn_q + 1'b1;
					end
					state_q <= gcrp_pkg::S_PUSH2;
				end
				gcrp_pkg::S_PUSH2: begin
					if (nn_q < gcrp_pkg::CC_W'(gcrp_pkg::BASE_DEPTH)) begin
						nn_q <= nn_q + 1'b1;
					end
					state_q <= gcrp_pkg::S_COMMIT;
				end
				gcrp_pkg::S_COMMIT: begin
					placed_cnt_q     <= placed_cnt_q + 1'b1;
					corner_cnt_q     <= nn_q;
					bank_q           <= !bank_q;
					hu_q             <= best_h_q[14:0];
					au_q             <= best_a_q[27:0];
					rem_q[best_sz_q] <= rem_q[best_sz_q] - 4'd1;
					tot_q            <= tot_q - 1'b1;
					state_q          <= gcrp_pkg::S_EMIT;
				end
				gcrp_pkg::S_EMIT: begin
					// hold until the output register is free
					if (emit_ok) begin
						o_page_q    <= page_q;
						o_err_q     <= err_q;
						if (err_q) begin
							o_x_q    <= '0;
							o_y_q    <= '0;
							o_w_q    <= '0;
							o_h_q    <= '0;
							o_sz_q   <= '0;
							o_rot_q  <= 1'b0;
							o_last_q <= 1'b1;
							state_q  <= gcrp_pkg::S_IDLE;
						end else begin
							o_x_q    <= br_q.x;
							o_y_q    <= br_q.y;
							o_w_q    <= br_q.w;
							o_h_q    <= br_q.h;
							o_sz_q   <= best_sz_q;
							o_rot_q  <= best_rot_q;
							o_last_q <= (tot_q == '0);
							state_q  <= (tot_q == '0) ? gcrp_pkg::S_IDLE : gcrp_pkg::S_START;
						end
					end
				end
				default: begin
					state_q <= gcrp_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign res.valid       = res_valid_q;
	assign res.page_index  = o_page_q;
	assign res.pos_x       = o_x_q;
	assign res.pos_y       = o_y_q;
	assign res.rect_width  = o_w_q;
	assign res.rect_height = o_h_q;
	assign res.size_code   = o_sz_q;
	assign res.rotated     = o_rot_q;
	assign res.no_fit      = o_err_q;
	assign res.last        = o_last_q;

endmodule
